[rtl/lmfe_pkg.sv]
// Shared constants, types and tables of the log-mel feature extractor.
package lmfe_pkg;

    localparam int FFT_SIZE_DEF   = 512;
    localparam int WINDOW_LEN_DEF = 400;
    localparam int MEL_BANDS_DEF  = 40;
    localparam int MAX_FRAMES_DEF = 255;

    localparam int RING_DEPTH = 512;
    localparam int RING_AW    = 9;
    localparam int TW_HALF    = 512;
    localparam int TW_AW      = 9;
    localparam int POW_SHIFT  = 12;
    localparam int POW_W      = 64 - POW_SHIFT;
    localparam int ACC_EXP    = 34;
    localparam int LOG_EPS    = 172;
    localparam int LOG10_MUL  = 1233;
    localparam longint TW_COS_Q30 = 64'sd1073721611;
    localparam longint TW_SIN_Q30 = 64'sd6588356;

    localparam int IDX_W    = 14;
    localparam int COEF_W   = 16;
    localparam int SMP_W    = 16;
    localparam int FEAT_W   = 16;
    localparam int BAND_W   = 6;
    localparam int FRAME_W  = 8;
    localparam int CNT10_W  = 10;
    localparam int CLAMP_W  = 15;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 3;

    localparam logic [1:0] MODE_WIN = 2'd0;
    localparam logic [1:0] MODE_MEL = 2'd1;
    localparam logic [1:0] MODE_PCM = 2'd2;

    localparam logic [CFG_AW-1:0] REG_FEAT_MEAN   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_FEAT_INVSTD = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FEAT_CLAMP  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_HOP_LEN     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_FRAME_LIMIT = 3'd4;

    typedef logic [11:0] frac_arr_t [32];
    localparam frac_arr_t FRAC_LOG2 = '{
        12'd0,    12'd182,  12'd358,  12'd530,  12'd696,  12'd858,  12'd1016, 12'd1169,
        12'd1319, 12'd1465, 12'd1607, 12'd1746, 12'd1882, 12'd2015, 12'd2145, 12'd2272,
        12'd2396, 12'd2518, 12'd2637, 12'd2754, 12'd2869, 12'd2982, 12'd3092, 12'd3200,
        12'd3307, 12'd3412, 12'd3514, 12'd3615, 12'd3715, 12'd3812, 12'd3908, 12'd4003
    };

    typedef logic signed [16:0] tw_arr_t [TW_HALF];

    function automatic longint rnd_sh(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic tw_arr_t tw_build(input bit want_sin);
        tw_arr_t t;
        longint c;
        longint s;
        longint nc;
        longint ns;
        c = 64'sd1 <<< 30;
        s = 64'sd0;
        for (int k = 0; k < TW_HALF; k++) begin
            t[k] = want_sin ? 17'(rnd_sh(s, 15)) : 17'(rnd_sh(c, 15));
            nc = rnd_sh(c * TW_COS_Q30 - s * TW_SIN_Q30, 30);
            ns = rnd_sh(s * TW_COS_Q30 + c * TW_SIN_Q30, 30);
            c = nc;
            s = ns;
        end
        return t;
    endfunction

    localparam tw_arr_t TW_COS_TAB = tw_build(1'b0);
    localparam tw_arr_t TW_SIN_TAB = tw_build(1'b1);

    typedef struct packed {
        logic       win_wr;
        logic       mel_wr;
        logic       ring_wr;
        logic       load_rd;
        logic       load_mul;
        logic       load_wr;
        logic       load_zero;
        logic       bf_rd;
        logic       bf_mul;
        logic       bf_wr_a;
        logic       bf_wr_b;
        logic       pw_rd;
        logic       pw_mul;
        logic       pw_wr;
        logic       mel_clr;
        logic       mel_issue;
        logic [5:0] log_step;
    } lmfe_cmd_t;

endpackage

[rtl/lmfe_dp.sv]
// Datapath: tables, sample ring, FFT and power memories, mel MAC, log and normalization.
module lmfe_dp import lmfe_pkg::*; #(
    parameter int FFT_SIZE   = FFT_SIZE_DEF,
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int MEL_BANDS  = MEL_BANDS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  lmfe_cmd_t                                 cmd,
    input  logic [$clog2(FFT_SIZE)-1:0]               addr_a,
    input  logic [$clog2(FFT_SIZE)-1:0]               addr_b,
    input  logic [TW_AW-1:0]                          tw_idx,
    input  logic [RING_AW-1:0]                        ring_addr,
    input  logic [$clog2((FFT_SIZE/2+1)*MEL_BANDS)-1:0] mel_addr,
    input  logic [IDX_W-1:0]                          in_index,
    input  logic [COEF_W-1:0]                         in_coef,
    input  logic signed [SMP_W-1:0]                   in_sample,
    input  logic signed [CFG_W-1:0]                   feat_mean,
    input  logic [CFG_W-1:0]                          feat_inv_std,
    input  logic [CLAMP_W-1:0]                        feat_clamp,
    output logic signed [FEAT_W-1:0]                  feature
);

    localparam int FFT_AW    = $clog2(FFT_SIZE);
    localparam int NBINS     = FFT_SIZE / 2 + 1;
    localparam int PW_AW     = $clog2(NBINS);
    localparam int MEL_DEPTH = NBINS * MEL_BANDS;
    localparam int MEL_AW    = $clog2(MEL_DEPTH);
    localparam int WIN_AW    = $clog2(WINDOW_LEN);

    logic [COEF_W-1:0]        win_mem  [WINDOW_LEN];
    logic [COEF_W-1:0]        mel_mem  [MEL_DEPTH];
    logic signed [SMP_W-1:0]  ring_mem [RING_DEPTH];
    logic signed [31:0]       re_mem   [FFT_SIZE];
    logic signed [31:0]       im_mem   [FFT_SIZE];
    logic [POW_W-1:0]         pow_mem  [NBINS];

    logic signed [SMP_W-1:0]  ring_q;
    logic [COEF_W-1:0]        win_q;
    logic signed [32:0]       lp_q;
    logic signed [31:0]       ur_q, ui_q, xr_q, xi_q;
    logic signed [16:0]       c_q, s_q;
    logic signed [48:0]       p1_q, p2_q, p3_q, p4_q;
    logic signed [34:0]       vr_q, vi_q;
    logic [63:0]              rr_q, qq_q;
    logic [POW_W-1:0]         pw_q;
    logic [COEF_W-1:0]        w_q;
    logic                     v1_reg, v2_reg;
    logic [63:0]              prod_q;
    logic [63:0]              acc_q;
    logic [63:0]              lv_q;
    logic [2:0]               grp_q;
    logic signed [19:0]       l2_q;
    logic signed [15:0]       l10_q;
    logic signed [33:0]       yp_q;

    logic [FFT_AW-1:0]        rev_a;
    logic                     fft_we;
    logic [FFT_AW-1:0]        fft_waddr;
    logic signed [31:0]       wre, wim;
    logic signed [49:0]       sum_r, sum_i;
    logic signed [34:0]       vr, vi;
    logic signed [32:0]       x_load;
    logic [63:0]              psum;
    logic [64:0]              acc_sum;
    logic [64:0]              eps_sum;
    logic [2:0]               grp;
    logic [7:0]               vbyte;
    logic [2:0]               bpos;
    logic [5:0]               e_w;
    logic [68:0]              vx;
    logic [4:0]               f_w;
    logic signed [19:0]       l2;
    logic signed [31:0]       l10p;
    logic signed [19:0]       l10r;
    logic signed [16:0]       dlt;
    logic signed [25:0]       y_r;
    logic signed [25:0]       cl;

    always_comb begin
        for (int j = 0; j < FFT_AW; j++) begin
            rev_a[j] = addr_a[FFT_AW-1-j];
        end
    end

    always_comb begin
        x_load = (lp_q + 33'sd16384) >>> 15;
        sum_r  = p1_q + p2_q;
        sum_i  = p3_q - p4_q;
        vr     = 35'((sum_r + 50'sd16384) >>> 15);
        vi     = 35'((sum_i + 50'sd16384) >>> 15);
        fft_we    = cmd.load_wr || cmd.bf_wr_a || cmd.bf_wr_b;
        fft_waddr = addr_a;
        wre       = '0;
        wim       = '0;
        if (cmd.load_wr) begin
            fft_waddr = rev_a;
            wre       = cmd.load_zero ? 32'sd0 : 32'(x_load);
        end else if (cmd.bf_wr_a) begin
            wre = 32'(ur_q + vr);
            wim = 32'(ui_q + vi);
        end else if (cmd.bf_wr_b) begin
            fft_waddr = addr_b;
            wre       = 32'(ur_q - vr_q);
            wim       = 32'(ui_q - vi_q);
        end
        psum = rr_q + qq_q;
    end

    always_ff @(posedge aclk) begin
        if (cmd.win_wr) begin
            win_mem[WIN_AW'(in_index)] <= in_coef;
        end
        if (cmd.mel_wr) begin
            mel_mem[MEL_AW'(in_index)] <= in_coef;
        end
        if (cmd.ring_wr) begin
            ring_mem[ring_addr] <= in_sample;
        end
        if (cmd.load_rd) begin
            ring_q <= ring_mem[ring_addr];
            win_q  <= win_mem[WIN_AW'(addr_a)];
        end
        if (cmd.load_mul) begin
            lp_q <= ring_q * $signed({1'b0, win_q});
        end
        if (fft_we) begin
            re_mem[fft_waddr] <= wre;
            im_mem[fft_waddr] <= wim;
        end
        if (cmd.bf_rd || cmd.pw_rd) begin
            ur_q <= re_mem[addr_a];
            ui_q <= im_mem[addr_a];
        end
        if (cmd.bf_rd) begin
            xr_q <= re_mem[addr_b];
            xi_q <= im_mem[addr_b];
            c_q  <= TW_COS_TAB[tw_idx];
            s_q  <= TW_SIN_TAB[tw_idx];
        end
        if (cmd.bf_mul) begin
            p1_q <= xr_q * c_q;
            p2_q <= xi_q * s_q;
            p3_q <= xi_q * c_q;
            p4_q <= xr_q * s_q;
        end
        if (cmd.bf_wr_a) begin
            vr_q <= vr;
            vi_q <= vi;
        end
        if (cmd.pw_mul) begin
            rr_q <= ur_q * ur_q;
            qq_q <= ui_q * ui_q;
        end
        if (cmd.pw_wr) begin
            pow_mem[PW_AW'(addr_a)] <= psum[63:POW_SHIFT];
        end
        if (cmd.mel_issue) begin
            pw_q <= pow_mem[PW_AW'(addr_a)];
            w_q  <= mel_mem[mel_addr];
        end
        prod_q <= 64'({16'b0, pw_q} * {52'b0, w_q});
    end

    always_comb begin
        acc_sum = {1'b0, acc_q} + {1'b0, prod_q};
        eps_sum = {1'b0, acc_q} + 65'(LOG_EPS);
        grp = '0;
        for (int g = 0; g < 8; g++) begin
            if (lv_q[g*8 +: 8] != 8'd0) begin
                grp = 3'(g);
            end
        end
        vbyte = lv_q[grp_q*8 +: 8];
        bpos  = '0;
        for (int b = 0; b < 8; b++) begin
            if (vbyte[b]) begin
                bpos = 3'(b);
            end
        end
        e_w  = {grp_q, bpos};
        vx   = {lv_q, 5'b0} >> e_w;
        f_w  = vx[4:0];
        l2   = ($signed({14'b0, e_w}) - 20'sd34) * 20'sd4096
             + $signed({8'b0, FRAC_LOG2[f_w]});
        l10p = l2_q * 32'sd1233;
        l10r = 20'((l10p + 32'sd2048) >>> 12);
        dlt  = 17'(l10_q) - 17'(feat_mean);
        y_r  = 26'((yp_q + 34'sd128) >>> 8);
        cl   = $signed({11'b0, feat_clamp});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.mel_issue;
            v2_reg <= v1_reg;
        end
        if (cmd.mel_clr) begin
            acc_q <= '0;
        end else if (v2_reg) begin
            acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
        end
        if (cmd.log_step[0]) begin
            lv_q <= eps_sum[64] ? '1 : eps_sum[63:0];
        end
        if (cmd.log_step[1]) begin
            grp_q <= grp;
        end
        if (cmd.log_step[2]) begin
            l2_q <= l2;
        end
        if (cmd.log_step[3]) begin
            if (l10r > 20'sd32767) begin
                l10_q <= 16'sd32767;
            end else if (l10r < -20'sd32768) begin
                l10_q <= -16'sd32768;
            end else begin
                l10_q <= 16'(l10r);
            end
        end
        if (cmd.log_step[4]) begin
            yp_q <= dlt * $signed({1'b0, feat_inv_std});
        end
        if (cmd.log_step[5]) begin
            if (y_r > cl) begin
                feature <= 16'(cl);
            end else if (y_r < -cl) begin
                feature <= 16'(-cl);
            end else begin
                feature <= 16'(y_r);
            end
        end
    end

endmodule

[rtl/lmfe_ctrl.sv]
// Controller: input handshake, clip and hop counters, frame sequencer, output handshake.
module lmfe_ctrl import lmfe_pkg::*; #(
    parameter int FFT_SIZE   = FFT_SIZE_DEF,
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int MEL_BANDS  = MEL_BANDS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [1:0]                                  in_mode,
    input  logic [IDX_W-1:0]                            in_index,
    input  logic                                        in_clip_start,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic                                        out_last,
    output logic [BAND_W-1:0]                           out_band,
    output logic [FRAME_W-1:0]                          out_frame,
    input  logic [CNT10_W-1:0]                          hop_len,
    input  logic [FRAME_W-1:0]                          frame_limit,
    output lmfe_cmd_t                                   cmd,
    output logic [$clog2(FFT_SIZE)-1:0]                 addr_a,
    output logic [$clog2(FFT_SIZE)-1:0]                 addr_b,
    output logic [TW_AW-1:0]                            tw_idx,
    output logic [RING_AW-1:0]                          ring_addr,
    output logic [$clog2((FFT_SIZE/2+1)*MEL_BANDS)-1:0] mel_addr
);

    localparam int FFT_AW    = $clog2(FFT_SIZE);
    localparam int NBINS     = FFT_SIZE / 2 + 1;
    localparam int MEL_DEPTH = NBINS * MEL_BANDS;
    localparam int MEL_AW    = $clog2(MEL_DEPTH);
    localparam int CNT_W     = FFT_AW + 1;
    localparam int STG_W     = $clog2(FFT_AW);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_FFT, ST_POW, ST_MEL, ST_LOG, ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           ph_reg, ph_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [STG_W-1:0]     stage_reg, stage_next;
    logic [BAND_W-1:0]    band_reg, band_next;
    logic [MEL_AW-1:0]    mel_addr_reg, mel_addr_next;
    logic [RING_AW-1:0]   wr_pos_reg, wr_pos_next;
    logic [CNT10_W-1:0]   sic_reg, sic_next;
    logic [CNT10_W-1:0]   hop_cnt_reg, hop_cnt_next;
    logic [FRAME_W-1:0]   frames_reg, frames_next;
    logic [FRAME_W-1:0]   frame_idx_reg, frame_idx_next;

    logic [CNT10_W-1:0]   sic_c, hop_c;
    logic [FRAME_W-1:0]   frames_c;
    logic                 due;
    logic [CNT_W-1:0]     bf_k;
    logic [CNT_W-1:0]     bf_a_full;
    logic [19:0]          tw_full;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_last  = (band_reg == BAND_W'(MEL_BANDS - 1));
    assign out_band  = band_reg;
    assign out_frame = frame_idx_reg;
    assign mel_addr  = mel_addr_reg;

    always_comb begin
        bf_k      = cnt_reg & ((CNT_W'(1) << stage_reg) - CNT_W'(1));
        bf_a_full = ((cnt_reg >> stage_reg) << (stage_reg + 1)) | bf_k;
        tw_full   = 20'(bf_k) << (TW_AW - 32'(stage_reg));
        tw_idx    = tw_full[TW_AW-1:0];
        if (state_reg == ST_FFT) begin
            addr_a = bf_a_full[FFT_AW-1:0];
        end else begin
            addr_a = cnt_reg[FFT_AW-1:0];
        end
        addr_b = addr_a | (FFT_AW'(1) << stage_reg);
        if (state_reg == ST_IDLE) begin
            ring_addr = wr_pos_reg;
        end else begin
            ring_addr = wr_pos_reg + RING_AW'(RING_DEPTH - WINDOW_LEN) + RING_AW'(cnt_reg);
        end
    end

    always_comb begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        cnt_next       = cnt_reg;
        stage_next     = stage_reg;
        band_next      = band_reg;
        mel_addr_next  = mel_addr_reg;
        wr_pos_next    = wr_pos_reg;
        sic_next       = sic_reg;
        hop_cnt_next   = hop_cnt_reg;
        frames_next    = frames_reg;
        frame_idx_next = frame_idx_reg;
        cmd            = '0;
        sic_c          = in_clip_start ? '0 : sic_reg;
        hop_c          = in_clip_start ? '0 : hop_cnt_reg;
        frames_c       = in_clip_start ? '0 : frames_reg;
        due            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_mode)
                        MODE_WIN: cmd.win_wr = (32'(in_index) < WINDOW_LEN);
                        MODE_MEL: cmd.mel_wr = (32'(in_index) < MEL_DEPTH);
                        MODE_PCM: begin
                            cmd.ring_wr  = 1'b1;
                            wr_pos_next  = wr_pos_reg + RING_AW'(1);
                            frames_next  = frames_c;
                            hop_cnt_next = hop_c;
                            sic_next     = sic_c;
                            if (32'(sic_c) < WINDOW_LEN) begin
                                sic_next = sic_c + CNT10_W'(1);
                                due      = (32'(sic_next) == WINDOW_LEN);
                            end else begin
                                if (hop_c != '0) begin
                                    hop_cnt_next = hop_c - CNT10_W'(1);
                                end
                                due = (hop_cnt_next == '0);
                            end
                            if (due) begin
                                hop_cnt_next = (hop_len == '0) ? CNT10_W'(1) : hop_len;
                                if (frames_c < frame_limit
                                        && frames_c < FRAME_W'(MAX_FRAMES)) begin
                                    frame_idx_next = frames_c;
                                    frames_next    = frames_c + FRAME_W'(1);
                                    state_next     = ST_LOAD;
                                    ph_next        = '0;
                                    cnt_next       = '0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                cmd.load_rd   = (ph_reg == 3'd0);
                cmd.load_mul  = (ph_reg == 3'd1);
                cmd.load_wr   = (ph_reg == 3'd2);
                cmd.load_zero = (32'(cnt_reg) >= WINDOW_LEN);
                ph_next       = ph_reg + 3'd1;
                if (ph_reg == 3'd2) begin
                    ph_next = '0;
                    if (cnt_reg == CNT_W'(FFT_SIZE - 1)) begin
                        state_next = ST_FFT;
                        cnt_next   = '0;
                        stage_next = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_FFT: begin
                cmd.bf_rd   = (ph_reg == 3'd0);
                cmd.bf_mul  = (ph_reg == 3'd1);
                cmd.bf_wr_a = (ph_reg == 3'd2);
                cmd.bf_wr_b = (ph_reg == 3'd3);
                ph_next     = ph_reg + 3'd1;
                if (ph_reg == 3'd3) begin
                    ph_next = '0;
                    if (cnt_reg == CNT_W'(FFT_SIZE / 2 - 1)) begin
                        cnt_next = '0;
                        if (stage_reg == STG_W'(FFT_AW - 1)) begin
                            state_next = ST_POW;
                        end else begin
                            stage_next = stage_reg + STG_W'(1);
                        end
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_POW: begin
                cmd.pw_rd  = (ph_reg == 3'd0);
                cmd.pw_mul = (ph_reg == 3'd1);
                cmd.pw_wr  = (ph_reg == 3'd2);
                ph_next    = ph_reg + 3'd1;
                if (ph_reg == 3'd2) begin
                    ph_next = '0;
                    if (cnt_reg == CNT_W'(FFT_SIZE / 2)) begin
                        state_next    = ST_MEL;
                        cnt_next      = '0;
                        band_next     = '0;
                        mel_addr_next = '0;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_MEL: begin
                cmd.mel_clr   = (cnt_reg == '0);
                cmd.mel_issue = (32'(cnt_reg) < NBINS);
                if (cmd.mel_issue) begin
                    mel_addr_next = mel_addr_reg + MEL_AW'(MEL_BANDS);
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(NBINS + 1)) begin
                    state_next = ST_LOG;
                    ph_next    = '0;
                end
            end
            ST_LOG: begin
                cmd.log_step = 6'(1) << ph_reg;
                ph_next      = ph_reg + 3'd1;
                if (ph_reg == 3'd5) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    if (out_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next    = ST_MEL;
                        band_next     = band_reg + BAND_W'(1);
                        cnt_next      = '0;
                        mel_addr_next = MEL_AW'(band_reg) + MEL_AW'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ph_reg        <= '0;
            cnt_reg       <= '0;
            stage_reg     <= '0;
            band_reg      <= '0;
            mel_addr_reg  <= '0;
            wr_pos_reg    <= '0;
            sic_reg       <= '0;
            hop_cnt_reg   <= '0;
            frames_reg    <= '0;
            frame_idx_reg <= '0;
        end else begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            cnt_reg       <= cnt_next;
            stage_reg     <= stage_next;
            band_reg      <= band_next;
            mel_addr_reg  <= mel_addr_next;
            wr_pos_reg    <= wr_pos_next;
            sic_reg       <= sic_next;
            hop_cnt_reg   <= hop_cnt_next;
            frames_reg    <= frames_next;
            frame_idx_reg <= frame_idx_next;
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("input and output words both open");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_ready && out_last) |=> in_ready)
        else $error("block not idle after last band");

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_rd, cmd.load_mul, cmd.load_wr, cmd.bf_rd, cmd.bf_mul,
                  cmd.bf_wr_a, cmd.bf_wr_b, cmd.pw_rd, cmd.pw_mul, cmd.pw_wr,
                  cmd.mel_issue, cmd.log_step}))
        else $error("datapath operations overlap");

    a_frame_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && $past(state_reg) == ST_IDLE)
            |-> (frames_reg == frame_idx_reg + FRAME_W'(1)))
        else $error("frame counter out of step");

endmodule

[rtl/log_mel_feature_extractor_unit.sv]
// Top level of the log-mel feature extractor: configuration registers and port packing.
//
// s_ channel takes one word per accepted beat: a window coefficient load, a mel weight
// load or a PCM sample (s_tuser[1:0] selects, s_tuser[2] marks the first sample of a clip).
// Loads and samples that start no frame are taken one per cycle. A sample that completes
// the first window of a clip, or a later hop, starts a frame while the frame limit allows:
// s_tready stays low while the frame is windowed, transformed (on one shared butterfly
// unit), turned into power bins and summed into mel bands (one multiply-accumulate per
// cycle), with log and scaling per band, and while its features are sent. Results leave
// on m_ one band per word, MEL_BANDS words per frame, m_tlast on the last band. While
// m_tready is low the current feature is held and no further work proceeds. Reset
// clears the clip, hop and frame counters and sets the configuration registers to their
// defaults; loaded tables are kept only as written. Configuration is written through
// cfg_wr_en / cfg_addr / cfg_wdata; the user must write it only while the block is
// idle, which the block itself does not enforce.
module log_mel_feature_extractor_unit import lmfe_pkg::*; #(
    parameter int FFT_SIZE   = FFT_SIZE_DEF,
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    parameter int MEL_BANDS  = MEL_BANDS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // index[13:0], coef[29:14], sample[45:30]
    input  logic [2:0]        s_tuser,   // mode[1:0], clip_start[2]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // feature[15:0], band[21:16], frame_index[29:22]
    output logic              m_tlast,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int FFT_AW = $clog2(FFT_SIZE);
    localparam int MEL_AW = $clog2((FFT_SIZE / 2 + 1) * MEL_BANDS);

    logic signed [CFG_W-1:0]  feat_mean_reg;
    logic [CFG_W-1:0]         feat_inv_std_reg;
    logic [CLAMP_W-1:0]       feat_clamp_reg;
    logic [CNT10_W-1:0]       hop_len_reg;
    logic [FRAME_W-1:0]       frame_limit_reg;

    lmfe_cmd_t                cmd;
    logic [FFT_AW-1:0]        addr_a, addr_b;
    logic [TW_AW-1:0]         tw_idx;
    logic [RING_AW-1:0]       ring_addr;
    logic [MEL_AW-1:0]        mel_addr;
    logic [BAND_W-1:0]        out_band;
    logic [FRAME_W-1:0]       out_frame;
    logic signed [FEAT_W-1:0] feature;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            feat_mean_reg    <= '0;
            feat_inv_std_reg <= CFG_W'(256);
            feat_clamp_reg   <= CLAMP_W'(32767);
            hop_len_reg      <= CNT10_W'(160);
            frame_limit_reg  <= FRAME_W'(98);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FEAT_MEAN:   feat_mean_reg    <= cfg_wdata;
                REG_FEAT_INVSTD: feat_inv_std_reg <= cfg_wdata;
                REG_FEAT_CLAMP:  feat_clamp_reg   <= cfg_wdata[CLAMP_W-1:0];
                REG_HOP_LEN:     hop_len_reg      <= cfg_wdata[CNT10_W-1:0];
                REG_FRAME_LIMIT: frame_limit_reg  <= cfg_wdata[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    lmfe_ctrl #(
        .FFT_SIZE   (FFT_SIZE),
        .WINDOW_LEN (WINDOW_LEN),
        .MEL_BANDS  (MEL_BANDS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_mode       (s_tuser[1:0]),
        .in_index      (s_tdata[13:0]),
        .in_clip_start (s_tuser[2]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_last      (m_tlast),
        .out_band      (out_band),
        .out_frame     (out_frame),
        .hop_len       (hop_len_reg),
        .frame_limit   (frame_limit_reg),
        .cmd           (cmd),
        .addr_a        (addr_a),
        .addr_b        (addr_b),
        .tw_idx        (tw_idx),
        .ring_addr     (ring_addr),
        .mel_addr      (mel_addr)
    );

    lmfe_dp #(
        .FFT_SIZE   (FFT_SIZE),
        .WINDOW_LEN (WINDOW_LEN),
        .MEL_BANDS  (MEL_BANDS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .addr_a       (addr_a),
        .addr_b       (addr_b),
        .tw_idx       (tw_idx),
        .ring_addr    (ring_addr),
        .mel_addr     (mel_addr),
        .in_index     (s_tdata[13:0]),
        .in_coef      (s_tdata[29:14]),
        .in_sample    (s_tdata[45:30]),
        .feat_mean    (feat_mean_reg),
        .feat_inv_std (feat_inv_std_reg),
        .feat_clamp   (feat_clamp_reg),
        .feature      (feature)
    );

    assign m_tdata = {2'b00, out_frame, out_band, feature};

endmodule

[sim/tb_log_mel_feature_extractor_unit.sv]
// Self-checking testbench of the log-mel feature extractor: table loads, clips and checked features.
module tb_log_mel_feature_extractor_unit import lmfe_pkg::*;;

    localparam int WLEN   = 400;
    localparam int NFFT   = 512;
    localparam int NBAND  = 40;
    localparam int NBIN   = NFFT / 2 + 1;
    localparam int MDEPTH = NBIN * NBAND;

    typedef struct {
        logic [15:0] feature;
        logic [5:0]  band;
        logic [7:0]  frame_index;
        logic        last;
    } feat_t;

    typedef struct {
        logic [1:0]  mode;
        logic [13:0] index;
        logic [15:0] coef;
        logic [15:0] sample;
        logic        clip_start;
    } word_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata = '0;   // index[13:0], coef[29:14], sample[45:30]
    logic [2:0]          s_tuser = '0;   // mode[1:0], clip_start[2]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;        // feature[15:0], band[21:16], frame_index[29:22]
    logic                m_tlast;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    log_mel_feature_extractor_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    longint       mean_q;
    longint       inv_std_q;
    longint       clamp_q;
    int unsigned  hop_q;
    int unsigned  limit_q;
    logic [15:0]  win_tab [WLEN];
    logic [15:0]  mel_tab [MDEPTH];
    logic [15:0]  ring [512];
    int unsigned  clip_cnt;
    int unsigned  hop_cnt;
    int unsigned  frame_cnt;
    int unsigned  wr_ptr;
    int           tw_c [512];
    int           tw_s [512];
    int           fr [NFFT];
    int           fi [NFFT];

    feat_t        feat_q[$];
    int           errors = 0;
    int           n_feat = 0;
    int           n_words = 0;
    int           frames_predicted = 0;
    bit           tx_idle_en = 1'b1;
    bit           rx_idle_en = 1'b1;

    function automatic longint rshift_round(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic void make_twiddles();
        longint c;
        longint s;
        longint nc;
        c = longint'(1) <<< 30;
        s = 0;
        for (int k = 0; k < 512; k++) begin
            tw_c[k] = int'(rshift_round(c, 15));
            tw_s[k] = int'(rshift_round(s, 15));
            nc = rshift_round(c * 64'sd1073721611 - s * 64'sd6588356, 30);
            s  = rshift_round(s * 64'sd1073721611 + c * 64'sd6588356, 30);
            c  = nc;
        end
    endfunction

    function automatic longint log10_of(logic [63:0] acc);
        logic [63:0] v;
        int e;
        int f;
        longint l2;
        longint l10;
        v = (acc > 64'hFFFF_FFFF_FFFF_FFFF - 64'd172) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + 64'd172;
        e = 63;
        while (e > 0 && !v[e]) e--;
        f = (e >= 5) ? int'((v >> (e - 5)) & 64'd31) : int'((v << (5 - e)) & 64'd31);
        l2 = longint'(e - 34) * 4096 + longint'(FRAC_LOG2[f]);
        l10 = rshift_round(l2 * 1233, 12);
        if (l10 > 32767) l10 = 32767;
        if (l10 < -32768) l10 = -32768;
        return l10;
    endfunction

    function automatic void predict_frame();
        int j;
        int half;
        int stride;
        int t;
        longint c;
        longint s;
        longint xr;
        longint xi;
        longint vr;
        longint vi;
        longint ur;
        longint ui;
        logic [63:0] pw;
        logic [63:0] term;
        logic [63:0] acc;
        longint y;
        feat_t ft;
        for (int i = 0; i < NFFT; i++) begin
            fr[i] = 0;
            fi[i] = 0;
            if (i < WLEN)
                fr[i] = int'(rshift_round(longint'($signed(ring[(wr_ptr + 512 - WLEN + i) % 512]))
                                          * longint'(win_tab[i]), 15));
        end
        for (int i = 0; i < NFFT; i++) begin
            j = 0;
            for (int b = 0; b < 9; b++) if (i & (1 << b)) j |= 1 << (8 - b);
            if (i < j) begin
                t = fr[i]; fr[i] = fr[j]; fr[j] = t;
                t = fi[i]; fi[i] = fi[j]; fi[j] = t;
            end
        end
        for (int len = 2; len <= NFFT; len <<= 1) begin
            half = len / 2;
            stride = 1024 / len;
            for (int i = 0; i < NFFT; i += len) begin
                for (int k = 0; k < half; k++) begin
                    c = tw_c[(k * stride) & 511];
                    s = tw_s[(k * stride) & 511];
                    ur = fr[i + k];
                    ui = fi[i + k];
                    xr = fr[i + k + half];
                    xi = fi[i + k + half];
                    vr = rshift_round(xr * c + xi * s, 15);
                    vi = rshift_round(xi * c - xr * s, 15);
                    fr[i + k] = int'(ur + vr);
                    fi[i + k] = int'(ui + vi);
                    fr[i + k + half] = int'(ur - vr);
                    fi[i + k + half] = int'(ui - vi);
                end
            end
        end
        for (int m = 0; m < NBAND; m++) begin
            acc = '0;
            for (int k = 0; k < NBIN; k++) begin
                pw = (64'(longint'(fr[k]) * longint'(fr[k]))
                      + 64'(longint'(fi[k]) * longint'(fi[k]))) >> 12;
                term = pw * {48'd0, mel_tab[k * NBAND + m]};
                acc = (acc > ~term) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + term;
            end
            y = rshift_round((log10_of(acc) - mean_q) * inv_std_q, 8);
            if (y > clamp_q) y = clamp_q;
            if (y < -clamp_q) y = -clamp_q;
            ft.feature = y[15:0];
            ft.band = m[5:0];
            ft.frame_index = frame_cnt[7:0];
            ft.last = (m == NBAND - 1);
            feat_q.push_back(ft);
        end
        frame_cnt++;
        frames_predicted++;
    endfunction

    function automatic void predict_word(word_t w);
        bit due;
        due = 1'b0;
        n_words++;
        case (w.mode)
            MODE_WIN: if (w.index < WLEN) win_tab[w.index] = w.coef;
            MODE_MEL: if (w.index < MDEPTH) mel_tab[w.index] = w.coef;
            MODE_PCM: begin
                if (w.clip_start) begin
                    clip_cnt = 0;
                    hop_cnt = 0;
                    frame_cnt = 0;
                end
                ring[wr_ptr] = w.sample;
                wr_ptr = (wr_ptr + 1) % 512;
                if (clip_cnt < WLEN) begin
                    clip_cnt++;
                    due = (clip_cnt == WLEN);
                end else begin
                    if (hop_cnt > 0) hop_cnt--;
                    due = (hop_cnt == 0);
                end
                if (due) begin
                    hop_cnt = (hop_q != 0) ? hop_q : 1;
                    if (frame_cnt < limit_q && frame_cnt < 255) predict_frame();
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        feat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_feat++;
            if (feat_q.size() == 0) begin
                report_mismatch("unexpected word, band", m_tdata[21:16], -1);
            end else begin
                e = feat_q.pop_front();
                if (m_tdata[15:0] !== e.feature)
                    report_mismatch("feature", $signed(m_tdata[15:0]), $signed(e.feature));
                if (m_tdata[21:16] !== e.band) report_mismatch("band", m_tdata[21:16], e.band);
                if (m_tdata[29:22] !== e.frame_index)
                    report_mismatch("frame_index", m_tdata[29:22], e.frame_index);
                if (m_tlast !== e.last) report_mismatch("last", m_tlast, e.last);
            end
        end
    end

    // receiver stalls in bursts
    int rx_hold = 0;
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            rx_hold <= $urandom_range(1, 10);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_word(word_t w);
        if (tx_idle_en && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {w.clip_start, w.mode};
        s_tdata <= {2'b00, w.sample, w.coef, w.index};
        do @(posedge aclk); while (!s_tready);
        predict_word(w);
    endtask

    task automatic send_pcm(logic [15:0] smp, logic cs);
        word_t w;
        w = '{MODE_PCM, 14'($urandom), 16'($urandom), smp, cs};
        send_word(w);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (feat_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] mean, logic [15:0] inv, logic [14:0] clmp,
                            logic [9:0] hop, logic [7:0] lim);
        logic [15:0] vals [5];
        vals = '{mean, inv, {1'b0, clmp}, {6'd0, hop}, {8'd0, lim}};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= CFG_AW'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        mean_q = longint'($signed(mean));
        inv_std_q = inv;
        clamp_q = clmp;
        hop_q = hop;
        limit_q = lim;
    endtask

    word_t directed [] = '{
        '{2'd3,       14'd5,     16'hFFFF, 16'h7FFF, 1'b1},
        '{MODE_WIN,   14'd400,   16'hFFFF, 16'h0000, 1'b0},
        '{MODE_WIN,   14'h3FFF,  16'h1234, 16'hFFFF, 1'b1},
        '{MODE_MEL,   14'd10280, 16'hFFFF, 16'h0000, 1'b0},
        '{MODE_MEL,   14'h3FFF,  16'hABCD, 16'h8000, 1'b1},
        '{MODE_PCM,   14'h3FFF,  16'hFFFF, 16'h8000, 1'b1},
        '{MODE_PCM,   14'd0,     16'd0,    16'h7FFF, 1'b0},
        '{MODE_PCM,   14'd0,     16'd0,    16'h0000, 1'b0},
        '{MODE_PCM,   14'd0,     16'd0,    16'hFFFF, 1'b0},
        '{MODE_PCM,   14'd0,     16'd0,    16'h0001, 1'b0}
    };

    initial begin
        #30_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        make_twiddles();
        mean_q = 0; inv_std_q = 256; clamp_q = 32767; hop_q = 160; limit_q = 98;
        clip_cnt = 0; hop_cnt = 0; frame_cnt = 0; wr_ptr = 0;
        foreach (ring[i]) ring[i] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill both tables before any frame reads them
        for (int i = 0; i < WLEN; i++)
            send_word('{MODE_WIN, 14'(i),
                        (i == 0) ? 16'h0000 : (i == WLEN - 1) ? 16'hFFFF : 16'($urandom),
                        16'($urandom), 1'($urandom)});
        for (int i = 0; i < MDEPTH; i++)
            send_word('{MODE_MEL, 14'(i), (i < NBAND) ? 16'hFFFF : 16'($urandom),
                        16'($urandom), 1'($urandom)});

        // reset settings, directed words, then one full clip
        foreach (directed[i]) send_word(directed[i]);
        for (int i = 0; i < 396; i++) send_pcm(16'($urandom), 1'b0);
        drain();

        // extreme scaling, hop of one, limit three; a short clip first
        set_regs(16'h8000, 16'hFFFF, 15'h7FFF, 10'd1, 8'd3);
        for (int i = 0; i < 100; i++) send_pcm(16'($urandom), i == 0);
        for (int i = 0; i < 406; i++) send_pcm((i & 1) ? 16'h7FFF : 16'h8001, i == 0);
        drain();

        // zero inverse std, zero clamp, zero hop
        set_regs(16'h7FFF, 16'h0000, 15'h0000, 10'd0, 8'd2);
        for (int i = 0; i < 403; i++) send_pcm(16'($urandom), i == 0);
        drain();

        // limit zero drops every frame
        set_regs(16'h0000, 16'd1, 15'd4096, 10'd512, 8'd0);
        for (int i = 0; i < 420; i++) send_pcm(16'($urandom), i == 0);
        drain();

        // random scaling, hop of 100, limit 255, and random words
        set_regs(16'($urandom), 16'($urandom_range(1, 65535)), 15'($urandom), 10'd100, 8'd255);
        for (int i = 0; i < 720; i++) begin
            if (i > 600) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            case ($urandom_range(0, 19))
                0: send_word('{MODE_WIN, 14'($urandom), 16'($urandom), 16'($urandom),
                               1'($urandom)});
                1: send_word('{2'd3, 14'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)});
                default: send_pcm($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 1) ? 16'h7FFF
                                  : 16'h8000) : 16'($urandom), i == 0);
            endcase
        end
        drain();

        $display("covered %0d input words and %0d frames, %0d feature words checked",
                 n_words, frames_predicted, n_feat);
        $display("settings: reset, extremes, zero inverse std, zero hop, zero limit, random");
        if (errors == 0 && feat_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
